@@ rtl/csem_pkg.sv @@
// ----------------------------------------------------------------------------
// csem_pkg
// Shared types and constants of the counting semaphore table: action and
// status codes, default sizes and the command/flag groups of the free list.
// ----------------------------------------------------------------------------
package csem_pkg;

	localparam int SEMS_DEF      = 64;
	localparam int COUNT_MAX_DEF = 65534;
	localparam int TASKS_DEF     = 64;
	localparam int BIN_COUNT_MAX = 1;

	localparam int GEN_W    = 16;
	localparam int COUNT_W  = 16;
	localparam int HANDLE_W = 32;
	localparam int INDEX_W  = 16;

	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_PEND   = 2'd2,
		ACT_POST   = 2'd3
	} csem_action_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_INVALID      = 4'd1,
		ST_OVERFLOW     = 4'd2,
		ST_ALL_BUSY     = 4'd3,
		ST_PENDED       = 4'd4,
		ST_UNAVAILABLE  = 4'd5,
		ST_IN_INTERRUPT = 4'd6,
		ST_SYSTEM_TASK  = 4'd7,
		ST_IN_LOCK      = 4'd8,
		ST_BLOCKED      = 4'd9
	} csem_status_t;

	// commands from the controller to the free list
	typedef struct packed {
		logic fill;
		logic rd;
		logic pop;
		logic push;
	} csem_fl_cmd_t;

	// free list occupancy flags
	typedef struct packed {
		logic empty;
		logic full;
	} csem_fl_flags_t;

endpackage

@@ rtl/counting_semaphore_table.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_table
// Table of SEMS counting semaphores with create, delete, pend and post.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid/in_ready channel (action, handle and
//   options); one result per request leaves on out_valid/out_ready (status,
//   new_handle, woke_waiter). A handle is generation in bits 31:16 and slot
//   index in bits 15:0.
//   Each transaction reads its semaphore entry from a synchronous table RAM,
//   updates it and writes it back. Delete, pend and post read the entry on
//   acceptance and register their result in the execute state; create
//   passes through a slot state first, since the slot number must first be
//   read from the free list RAM before the entry can be read.
//   One request is processed at a time.
//   After reset the block sweeps both RAMs, one entry per cycle, over all
//   SEMS entries (clearing the table and loading the free list with 0..SEMS-1);
//   in_ready stays low during the sweep.
//   The result sits in an output register; a new request may be accepted
//   while it waits, but that request completes only once the receiver has
//   taken the pending result.
// ----------------------------------------------------------------------------
module counting_semaphore_table #(
	parameter int SEMS      = csem_pkg::SEMS_DEF,
	parameter int COUNT_MAX = csem_pkg::COUNT_MAX_DEF,
	parameter int TASKS     = csem_pkg::TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] handle,
	input  logic [15:0] init_count,
	input  logic        binary,
	input  logic        may_wait,
	input  logic        in_interrupt,
	input  logic        system_task,
	input  logic        preemptable,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [31:0] new_handle,
	output logic        woke_waiter
);

	localparam int IDX_W  = (SEMS > 1) ? $clog2(SEMS) : 1;
	localparam int WAIT_W = $clog2(TASKS + 1);
	localparam int GEN_W  = csem_pkg::GEN_W;
	localparam int CNT_W  = csem_pkg::COUNT_W;

	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SEMS - 1);
	localparam logic [15:0]       SEMS_LIM  = 16'(SEMS);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(COUNT_MAX);
	localparam logic [CNT_W-1:0]  BIN_MAX   = CNT_W'(csem_pkg::BIN_COUNT_MAX);
	localparam logic [WAIT_W-1:0] WAIT_MAX  = WAIT_W'(TASKS);

	typedef struct packed {
		logic              used;
		logic [GEN_W-1:0]  gen;
		logic [WAIT_W-1:0] waiters;
		logic [CNT_W-1:0]  count;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SLOT,
		S_EXEC
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] clr_q;

	// captured request
	csem_pkg::csem_action_t action_q;
	logic [31:0] handle_q;
	logic [15:0] init_q;
	logic        binary_q;
	logic        may_wait_q;
	logic        in_int_q;
	logic        sys_task_q;
	logic        preempt_q;

	// result register
	logic                  out_valid_q;
	csem_pkg::csem_status_t status_q;
	logic [31:0]           new_handle_q;
	logic                  woke_q;

	logic accept;
	logic commit;

	// table RAM
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	// free list
	csem_pkg::csem_fl_cmd_t   fl_cmd;
	csem_pkg::csem_fl_flags_t fl_flags;
	logic [IDX_W-1:0]         fl_rdata;

	// execute stage decisions
	csem_pkg::csem_status_t ex_status;
	logic [31:0]            ex_handle;
	logic                   ex_woke;
	logic                   ex_we;
	logic [IDX_W-1:0]       ex_addr;
	entry_t                 ex_entry;
	logic                   ex_pop;
	logic                   ex_push;

	logic [IDX_W-1:0] idx;
	logic             idx_ok;
	logic             live;
	logic [CNT_W-1:0] create_max;

	assign accept = in_valid && in_ready;
	assign commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign new_handle  = new_handle_q;
	assign woke_waiter = woke_q;

	assign idx        = handle_q[IDX_W-1:0];
	assign idx_ok     = (handle_q[15:0] < SEMS_LIM);
	assign live       = ram_rdata.used && (ram_rdata.gen == handle_q[31:16]);
	assign create_max = binary_q ? BIN_MAX : CNT_MAX;

	always_comb begin
		ex_status = csem_pkg::ST_OK;
		ex_handle = '0;
		ex_woke   = 1'b0;
		ex_we     = 1'b0;
		ex_addr   = idx;
		ex_entry  = ram_rdata;
		ex_pop    = 1'b0;
		ex_push   = 1'b0;
		unique case (action_q)
			csem_pkg::ACT_CREATE: begin
				ex_addr = fl_rdata;
				if (init_q > create_max) begin
					ex_status = csem_pkg::ST_OVERFLOW;
				end else if (fl_flags.empty) begin
					ex_status = csem_pkg::ST_ALL_BUSY;
				end else begin
					ex_pop           = 1'b1;
					ex_we            = 1'b1;
					ex_entry.used    = 1'b1;
					ex_entry.waiters = '0;
					ex_entry.count   = init_q;
					ex_handle        = {ram_rdata.gen, 16'(fl_rdata)};
				end
			end
			csem_pkg::ACT_DELETE: begin
				if (!idx_ok || !live) begin
					ex_status = csem_pkg::ST_INVALID;
				end else if (ram_rdata.waiters != '0) begin
					ex_status = csem_pkg::ST_PENDED;
				end else begin
					ex_push       = !fl_flags.full;
					ex_we         = 1'b1;
					ex_entry.used = 1'b0;
					ex_entry.gen  = ram_rdata.gen + GEN_W'(1);
				end
			end
			csem_pkg::ACT_PEND: begin
				priority if (!idx_ok) begin
					ex_status = csem_pkg::ST_INVALID;
				end else if (in_int_q) begin
					ex_status = csem_pkg::ST_IN_INTERRUPT;
				end else if (sys_task_q) begin
					ex_status = csem_pkg::ST_SYSTEM_TASK;
				end else if (!live) begin
					ex_status = csem_pkg::ST_INVALID;
				end else if (ram_rdata.count != '0) begin
					ex_we          = 1'b1;
					ex_entry.count = ram_rdata.count - CNT_W'(1);
				end else if (!may_wait_q) begin
					ex_status = csem_pkg::ST_UNAVAILABLE;
				end else if (!preempt_q) begin
					ex_status = csem_pkg::ST_IN_LOCK;
				end else begin
					ex_status = csem_pkg::ST_BLOCKED;
					// waiter count saturates at the task limit
					if (ram_rdata.waiters < WAIT_MAX) begin
						ex_we            = 1'b1;
						ex_entry.waiters = ram_rdata.waiters + WAIT_W'(1);
					end
				end
			end
			csem_pkg::ACT_POST: begin
				if (!idx_ok || !live) begin
					ex_status = csem_pkg::ST_INVALID;
				end else if (ram_rdata.count == CNT_MAX) begin
					ex_status = csem_pkg::ST_OVERFLOW;
				end else if (ram_rdata.waiters != '0) begin
					ex_we            = 1'b1;
					ex_woke          = 1'b1;
					ex_entry.waiters = ram_rdata.waiters - WAIT_W'(1);
				end else begin
					ex_we          = 1'b1;
					ex_entry.count = ram_rdata.count + CNT_W'(1);
				end
			end
			default: begin
				ex_status = csem_pkg::ST_INVALID;
			end
		endcase
	end

	// table RAM port muxing: sweep, entry read, write-back
	always_comb begin
		ram_we    = (state_q == S_CLEAR) || (commit && ex_we);
		ram_waddr = (state_q == S_CLEAR) ? clr_q : ex_addr;
		ram_wdata = (state_q == S_CLEAR) ? entry_t'('0) : ex_entry;
		ram_re    = accept || (state_q == S_SLOT);
		ram_raddr = (state_q == S_SLOT) ? fl_rdata : handle[IDX_W-1:0];
	end

	always_comb begin
		fl_cmd.fill = (state_q == S_CLEAR);
		fl_cmd.rd   = accept && (csem_pkg::csem_action_t'(action) == csem_pkg::ACT_CREATE);
		fl_cmd.pop  = commit && ex_pop;
		fl_cmd.push = commit && ex_push;
	end

	csem_ram #(
		.DEPTH  (SEMS),
		.DATA_W ($bits(entry_t)),
		.ADDR_W (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	csem_free_list #(
		.SEMS  (SEMS),
		.IDX_W (IDX_W)
	) u_free_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (fl_cmd),
		.fill_idx (clr_q),
		.push_idx (idx),
		.rdata    (fl_rdata),
		.flags    (fl_flags)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= csem_pkg::csem_action_t'(action);
			handle_q   <= handle;
			init_q     <= init_count;
			binary_q   <= binary;
			may_wait_q <= may_wait;
			in_int_q   <= in_interrupt;
			sys_task_q <= system_task;
			preempt_q  <= preemptable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= csem_pkg::ST_OK;
			new_handle_q <= '0;
			woke_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (csem_pkg::csem_action_t'(action) == csem_pkg::ACT_CREATE) begin
							state_q <= S_SLOT;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_SLOT: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q  <= 1'b1;
				status_q     <= ex_status;
				new_handle_q <= ex_handle;
				woke_q       <= ex_woke;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/csem_ram.sv @@
// ----------------------------------------------------------------------------
// csem_ram
// Single write port, single read port synchronous RAM with a registered
// read; read data holds until the next read enable.
// ----------------------------------------------------------------------------
module csem_ram #(
	parameter int DEPTH  = csem_pkg::SEMS_DEF,
	parameter int DATA_W = 40,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/csem_free_list.sv @@
// ----------------------------------------------------------------------------
// csem_free_list
// FIFO of free slot numbers held in a synchronous memory, with head, tail
// and fill level. Filled with 0..SEMS-1 by a sweep after reset.
// ----------------------------------------------------------------------------
module csem_free_list #(
	parameter int SEMS   = csem_pkg::SEMS_DEF,
	parameter int IDX_W  = (SEMS > 1) ? $clog2(SEMS) : 1,
	parameter int LVL_W  = $clog2(SEMS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  csem_pkg::csem_fl_cmd_t  cmd,
	input  logic [IDX_W-1:0]        fill_idx,
	input  logic [IDX_W-1:0]        push_idx,
	output logic [IDX_W-1:0]        rdata,
	output csem_pkg::csem_fl_flags_t flags
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(SEMS - 1);
	localparam logic [LVL_W-1:0] FULL = LVL_W'(SEMS);

	logic [IDX_W-1:0] fifo [SEMS];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [LVL_W-1:0] level_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] wdata;

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		return (p == LAST) ? '0 : p + IDX_W'(1);
	endfunction

	assign we    = cmd.fill || cmd.push;
	assign waddr = cmd.fill ? fill_idx : tail_q;
	assign wdata = cmd.fill ? fill_idx : push_idx;

	assign flags.empty = (level_q == '0);
	assign flags.full  = (level_q == FULL);

	always_ff @(posedge clk) begin
		if (we) begin
			fifo[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rdata <= fifo[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= FULL;
		end else begin
			if (cmd.pop) begin
				head_q <= next_pos(head_q);
			end
			if (cmd.push) begin
				tail_q <= next_pos(tail_q);
			end
			if (cmd.pop && !cmd.push) begin
				level_q <= level_q - LVL_W'(1);
			end else if (cmd.push && !cmd.pop) begin
				level_q <= level_q + LVL_W'(1);
			end
		end
	end

endmodule

@@ tb/sv/csem_checker.sv @@
// ----------------------------------------------------------------------------
// csem_checker
// Watches both channels of the counting semaphore table, keeps its own copy
// of the semaphore table and free list, works out the reply to every
// accepted request and compares each returned reply against the oldest one
// still outstanding. Hands the mismatch count and the number of outstanding
// replies to the testbench top.
// ----------------------------------------------------------------------------
module csem_checker
	import csem_pkg::*;
#(
	parameter int SEMS      = SEMS_DEF,
	parameter int COUNT_MAX = COUNT_MAX_DEF,
	parameter int TASKS     = TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] handle,
	input  logic [15:0] init_count,
	input  logic        binary,
	input  logic        may_wait,
	input  logic        in_interrupt,
	input  logic        system_task,
	input  logic        preemptable,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  status,
	input  logic [31:0] new_handle,
	input  logic        woke_waiter,

	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		csem_status_t      status;
		logic [31:0]       new_handle;
		logic              woke;
	} sem_reply_t;

	logic [COUNT_W-1:0] count_tbl   [SEMS];
	bit                 used_tbl    [SEMS];
	logic [GEN_W-1:0]   gen_tbl     [SEMS];
	int                 waiters_tbl [SEMS];
	int                 free_slot   [SEMS];
	int                 free_rd;
	int                 free_wr;
	int                 free_cnt;

	sem_reply_t replies_due[$];
	sem_reply_t want;
	int         reply_no;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("%0t: reply %0d %s: got %0h, want %0h", $time, reply_no, what, got,
			exp_val);
		fail_count++;
	endtask

	// applies one request to the table copy and returns the reply it earns
	function automatic sem_reply_t serve_request(csem_action_t act, logic [31:0] hdl,
			logic [15:0] init, logic bin, logic can_wait, logic intr, logic sys,
			logic preempt);
		sem_reply_t r;
		int slot;
		int cap;
		bit live;
		r.status = ST_OK;
		r.new_handle = '0;
		r.woke = 1'b0;
		slot = int'(hdl[15:0]);
		live = 1'b0;
		if (slot < SEMS) begin
			live = used_tbl[slot] && hdl[31:16] == gen_tbl[slot];
		end

		if (act == ACT_CREATE) begin
			cap = bin ? BIN_COUNT_MAX : COUNT_MAX;
			// count limit is checked before the free list
			if (int'(init) > cap) begin
				r.status = ST_OVERFLOW;
			end else if (free_cnt == 0) begin
				r.status = ST_ALL_BUSY;
			end else begin
				slot = free_slot[free_rd] % SEMS;
				free_rd = (free_rd + 1) % SEMS;
				free_cnt--;
				count_tbl[slot] = init;
				used_tbl[slot] = 1'b1;
				waiters_tbl[slot] = 0;
				r.new_handle = {gen_tbl[slot], 16'(slot)};
			end
		end else if (slot >= SEMS) begin
			r.status = ST_INVALID;
		end else if (act == ACT_DELETE) begin
			if (!live) begin
				r.status = ST_INVALID;
			end else if (waiters_tbl[slot] != 0) begin
				r.status = ST_PENDED;
			end else begin
				if (free_cnt < SEMS) begin
					free_slot[free_wr] = slot;
					free_wr = (free_wr + 1) % SEMS;
					free_cnt++;
				end
				used_tbl[slot] = 1'b0;
				gen_tbl[slot] = gen_tbl[slot] + 1'b1;
			end
		end else if (act == ACT_PEND) begin
			// context checks come after the slot range check but ahead of the live handle check
			if (intr) begin
				r.status = ST_IN_INTERRUPT;
			end else if (sys) begin
				r.status = ST_SYSTEM_TASK;
			end else if (!live) begin
				r.status = ST_INVALID;
			end else if (count_tbl[slot] != 0) begin
				count_tbl[slot] = count_tbl[slot] - 1'b1;
			end else if (!can_wait) begin
				r.status = ST_UNAVAILABLE;
			end else if (!preempt) begin
				r.status = ST_IN_LOCK;
			end else begin
				if (waiters_tbl[slot] < TASKS) begin
					waiters_tbl[slot]++;
				end
				r.status = ST_BLOCKED;
			end
		end else begin
			// a count at the limit refuses the post even with waiters
			if (!live) begin
				r.status = ST_INVALID;
			end else if (count_tbl[slot] == COUNT_MAX) begin
				r.status = ST_OVERFLOW;
			end else if (waiters_tbl[slot] != 0) begin
				waiters_tbl[slot]--;
				r.woke = 1'b1;
			end else begin
				count_tbl[slot] = count_tbl[slot] + 1'b1;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SEMS; i++) begin
				count_tbl[i] = '0;
				used_tbl[i] = 1'b0;
				gen_tbl[i] = '0;
				waiters_tbl[i] = 0;
				free_slot[i] = i;
			end
			free_rd = 0;
			free_wr = 0;
			free_cnt = SEMS;
			replies_due.delete();
			reply_no = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("reply with no request outstanding", {28'd0, status}, '0);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status) begin
						report_mismatch("status", {28'd0, status}, {28'd0, want.status});
					end
					if (new_handle !== want.new_handle) begin
						report_mismatch("new_handle", new_handle, want.new_handle);
					end
					if (woke_waiter !== want.woke) begin
						report_mismatch("woke_waiter", {31'd0, woke_waiter}, {31'd0, want.woke});
					end
				end
				reply_no++;
			end
			if (in_valid && in_ready) begin
				replies_due.push_back(serve_request(csem_action_t'(action), handle, init_count,
					binary, may_wait, in_interrupt, system_task, preemptable));
			end
			pending = replies_due.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the counting semaphore table. Drives directed requests,
// repeated reuse of a single recycled slot, and random request streams
// built around live, stale and malformed handles, with random idling on both
// channels. The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_top;
	import csem_pkg::*;

	localparam int RANDOM_ITEMS  = 750;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE        = 20;
	localparam int LIMIT_TICKS   = 80_000_000;
	localparam int RECYCLE_TURNS = 8;

	localparam logic [3:0] PF_WAIT    = 4'b1000;
	localparam logic [3:0] PF_IRQ     = 4'b0100;
	localparam logic [3:0] PF_SYS     = 4'b0010;
	localparam logic [3:0] PF_PREEMPT = 4'b0001;

	typedef struct packed {
		csem_action_t act;
		logic [31:0]  hdl;
		logic [15:0]  init;
		logic         bin;
		logic         can_wait;
		logic         intr;
		logic         sys;
		logic         preempt;
	} sem_req_t;

	typedef struct packed {
		csem_action_t act;
		logic [31:0]  hdl;
	} sent_req_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  action       = '0;
	logic [31:0] handle       = '0;
	logic [15:0] init_count   = '0;
	logic        binary       = 1'b0;
	logic        may_wait     = 1'b0;
	logic        in_interrupt = 1'b0;
	logic        system_task  = 1'b0;
	logic        preemptable  = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [3:0]  status;
	logic [31:0] new_handle;
	logic        woke_waiter;

	int fail_count;
	int pending;

	bit          no_idle   = 1'b0;
	bit          hold_due  = 1'b0;
	bit          hold_done = 1'b0;
	int          offered   = 0;
	logic [31:0] live_handles[$];
	logic [31:0] stale_handles[$];
	sent_req_t   sent_reqs[$];
	sent_req_t   done_req;

	counting_semaphore_table u_top (.*);

	csem_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#(LIMIT_TICKS);
		$display("simulation failed");
		$finish;
	end

	function automatic int idle_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_idle || p < 50) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic sem_req_t req_of(csem_action_t act, logic [31:0] hdl,
			logic [15:0] init = 16'd0, logic bin = 1'b0,
			logic [3:0] flags = PF_WAIT | PF_PREEMPT);
		sem_req_t r;
		r.act = act;
		r.hdl = hdl;
		r.init = init;
		r.bin = bin;
		r.can_wait = |(flags & PF_WAIT);
		r.intr = |(flags & PF_IRQ);
		r.sys = |(flags & PF_SYS);
		r.preempt = |(flags & PF_PREEMPT);
		return r;
	endfunction

	function automatic logic [31:0] pick_handle();
		int p;
		p = $urandom_range(0, 99);
		if (p < 75 && live_handles.size() > 0)
			return live_handles[$urandom_range(0, live_handles.size() - 1)];
		if (p < 87 && stale_handles.size() > 0)
			return stale_handles[$urandom_range(0, stale_handles.size() - 1)];
		if (p < 94) return {16'($urandom), 16'($urandom_range(0, SEMS_DEF - 1))};
		return $urandom;
	endfunction

	function automatic sem_req_t random_req();
		sem_req_t r;
		int p;
		int q;
		p = $urandom_range(0, 99);
		q = $urandom_range(0, 99);
		r.act = p < 22 ? ACT_CREATE : p < 42 ? ACT_DELETE : p < 72 ? ACT_PEND : ACT_POST;
		r.hdl = pick_handle();
		if (q < 55) r.init = 16'($urandom_range(0, 3));
		else if (q < 70) r.init = 16'($urandom_range(COUNT_MAX_DEF - 1, 16'hFFFF));
		else r.init = 16'($urandom);
		r.bin = ($urandom_range(0, 3) == 0);
		r.can_wait = ($urandom_range(0, 9) < 7);
		r.intr = ($urandom_range(0, 9) == 0);
		r.sys = ($urandom_range(0, 9) == 0);
		r.preempt = ($urandom_range(0, 9) < 8);
		return r;
	endfunction

	task automatic issue(sem_req_t r);
		int gap;
		gap = idle_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		action       <= r.act;
		handle       <= r.hdl;
		init_count   <= r.init;
		binary       <= r.bin;
		may_wait     <= r.can_wait;
		in_interrupt <= r.intr;
		system_task  <= r.sys;
		preemptable  <= r.preempt;
		do @(posedge clk); while (!in_ready);
		offered++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// piles more waiters than there are tasks on one semaphore, then unwinds
	task automatic pile_up();
		logic [31:0] h;
		issue(req_of(ACT_CREATE, 32'h0, 16'd0));
		drain();
		hold_due = 1'b1;
		h = live_handles.size() > 0 ? live_handles[$] : 32'h0;
		repeat (TASKS_DEF + 4) begin
			issue(req_of(ACT_PEND, h, 16'd0, 1'b0,
				($urandom_range(0, 9) == 0) ? 4'($urandom) : PF_WAIT | PF_PREEMPT));
		end
		issue(req_of(ACT_DELETE, h));
		repeat (TASKS_DEF + 6) issue(req_of(ACT_POST, h));
		issue(req_of(ACT_DELETE, h));
	endtask

	// walks a count up into the post limit
	task automatic limit_run();
		logic [31:0] h;
		issue(req_of(ACT_CREATE, 32'h0, 16'(COUNT_MAX_DEF - 2)));
		drain();
		h = live_handles.size() > 0 ? live_handles[$] : 32'h0;
		repeat (4) issue(req_of(ACT_POST, h));
		issue(req_of(ACT_PEND, h));
		issue(req_of(ACT_POST, h));
		issue(req_of(ACT_POST, h));
		issue(req_of(ACT_DELETE, h));
	endtask

	// tracks which handles are live or retired, from the replies
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready && sent_reqs.size() > 0) begin
				done_req = sent_reqs.pop_front();
				if (status == ST_OK && done_req.act == ACT_CREATE) begin
					live_handles.push_back(new_handle);
				end else if (status == ST_OK && done_req.act == ACT_DELETE) begin
					for (int i = live_handles.size() - 1; i >= 0; i--) begin
						if (live_handles[i] == done_req.hdl) live_handles.delete(i);
					end
					stale_handles.push_back(done_req.hdl);
					if (stale_handles.size() > 32) void'(stale_handles.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				sent_reqs.push_back('{act: csem_action_t'(action), hdl: handle});
			end
		end
	end

	initial begin : result_sink
		int burst;
		int stall;
		wait (arst_n);
		forever begin
			burst = $urandom_range(1, 30);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (burst - 1) @(negedge clk);
			stall = idle_gap();
			if (hold_due && !hold_done) begin
				stall = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] sem_a;
		logic [31:0] sem_b;
		logic [31:0] sem_c;
		logic [31:0] spin;
		logic [31:0] snapshot[$];
		int start;
		int p;
		sem_a = 32'h0000_0000;
		sem_b = 32'h0000_0001;
		sem_c = 32'h0000_0002;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fresh table hands out slots 0, 1, 2 in order
		issue(req_of(ACT_CREATE, 32'h0, 16'd2));
		issue(req_of(ACT_CREATE, 32'h0, 16'd2, 1'b1));
		issue(req_of(ACT_CREATE, 32'h0, 16'hFFFF));
		issue(req_of(ACT_CREATE, 32'h0, 16'd1, 1'b1));
		issue(req_of(ACT_CREATE, 32'h0, 16'(COUNT_MAX_DEF)));
		issue(req_of(ACT_POST, sem_c));
		issue(req_of(ACT_PEND, sem_a, 16'd0, 1'b0, PF_IRQ | PF_SYS));
		issue(req_of(ACT_PEND, {16'h0, 16'(SEMS_DEF)}, 16'd0, 1'b0, PF_IRQ));
		issue(req_of(ACT_PEND, {16'h1, 16'h0}, 16'd0, 1'b0, PF_SYS));
		issue(req_of(ACT_PEND, {16'h1, 16'h0}));
		issue(req_of(ACT_PEND, sem_a));
		issue(req_of(ACT_PEND, sem_a));
		issue(req_of(ACT_PEND, sem_a, 16'd0, 1'b0, 4'b0000));
		issue(req_of(ACT_PEND, sem_a, 16'd0, 1'b0, PF_WAIT));
		issue(req_of(ACT_PEND, sem_a));
		issue(req_of(ACT_DELETE, sem_a));
		issue(req_of(ACT_POST, sem_a));
		issue(req_of(ACT_POST, sem_a));
		issue(req_of(ACT_DELETE, sem_a));
		issue(req_of(ACT_DELETE, sem_a));
		issue(req_of(ACT_POST, sem_a));
		issue(req_of(ACT_DELETE, 32'hFFFF_FFFF));
		issue(req_of(ACT_POST, {16'h0, 16'(SEMS_DEF - 1)}));
		issue(req_of(ACT_POST, sem_b));
		issue(req_of(ACT_CREATE, 32'h0, 16'd0));
		drain();

		// fill the table, then one more create finds it full
		repeat (SEMS_DEF - live_handles.size()) issue(req_of(ACT_CREATE, 32'h0, 16'd0));
		issue(req_of(ACT_CREATE, 32'h0, 16'd0));
		drain();

		// with a single free slot, create and delete keep reusing it and
		// move its generation on each turn
		spin = live_handles[$];
		issue(req_of(ACT_DELETE, spin));
		no_idle = 1'b1;
		for (int k = 0; k < RECYCLE_TURNS; k++) begin
			spin[31:16] = spin[31:16] + 1'b1;
			issue(req_of(ACT_CREATE, 32'h0, 16'(k % 100)));
			issue(req_of(ACT_DELETE, spin));
		end
		no_idle = 1'b0;
		drain();

		snapshot = live_handles;
		foreach (snapshot[i]) issue(req_of(ACT_DELETE, snapshot[i]));
		drain();

		start = offered;
		pile_up();
		while (offered - start < RANDOM_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 1) pile_up();
			else if (p < 5) limit_run();
			else issue(random_req());
		end

		drain();
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/csem_pkg.sv
rtl/csem_ram.sv
rtl/csem_free_list.sv
rtl/counting_semaphore_table.sv
tb/sv/csem_checker.sv
tb/sv/tb_top.sv
